FILE: sv/trro_pkg.sv
// ============================================================================
// trro_pkg - shared definitions for the thick rectangle outline rasterizer
// Constants, register codes, request kinds and edge codes used by the block.
// ============================================================================
package trro_pkg;

    // Default sizing (MAX_CANVAS is expected to be a power of two)
    localparam int MAX_CANVAS_DEF = 1024;
    localparam int MAX_BRUSH_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // Configuration register widths and port sizes
    localparam int CANVAS_REG_W = 11;
    localparam int BRUSH_REG_W  = 7;
    localparam int COLOR_W      = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    // Register values after reset
    localparam logic [CANVAS_REG_W-1:0] CANVAS_W_RST = 11'd64;
    localparam logic [CANVAS_REG_W-1:0] CANVAS_H_RST = 11'd64;
    localparam logic [BRUSH_REG_W-1:0]  BRUSH_RST    = 7'd1;
    localparam logic [COLOR_W-1:0]      COLOR_RST    = 32'd0;

    // Request kinds carried in the input tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_BRUSH_SIZE    = 2'd2,
        CFG_DRAW_COLOR    = 2'd3
    } cfg_index_t;

    // Rectangle edges in drawing order
    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_BOTTOM = 2'd1,
        EDGE_LEFT   = 2'd2,
        EDGE_RIGHT  = 2'd3
    } edge_t;

endpackage

FILE: sv/thick_rectangle_outline_raster.sv
// ============================================================================
// thick_rectangle_outline_raster - rectangle outline drawn with a square brush
// Walks Bresenham lines along the rectangle's sides and scans a clipped square stamp
// at every line point, at most one pixel write per step tick.
// ============================================================================
// Usage: send a start item (tuser = 0) with two corners in tdata, then send
// step items (tuser = 1); every step item accepted while a rectangle is in
// progress returns exactly one result item, either one pixel write
// (tuser = 1) or an empty tick (tuser = 0) for a stamp that clipping left with
// no pixel. tlast marks the result of the rectangle's final tick; after it,
// steps return nothing until the next start. A start gives no result and
// replaces any rectangle in progress. For every item, start or step, the
// corner ordering, the Bresenham update of the line point and the clipping
// of the next stamp all sit in one combinational stage between the state
// registers and the result register, so a new item is taken in every cycle
// unless the result register is held by a stalled receiver, and its result
// shows in the cycle after acceptance. The result register doubles as the
// output stage: the input side stays ready while the held result is being
// taken in the same cycle. Stamp clipping uses the canvas and brush
// registers as they are when the stamp begins; pixel color is draw_color at
// the tick. Write configuration only while no rectangle is in progress.
// ============================================================================
module thick_rectangle_outline_raster #(
    parameter int MAX_CANVAS = trro_pkg::MAX_CANVAS_DEF,
    parameter int MAX_BRUSH  = trro_pkg::MAX_BRUSH_DEF,
    parameter int COORD_BITS = trro_pkg::COORD_BITS_DEF,
    localparam int PIX_W       = $clog2(MAX_CANVAS),
    localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * PIX_W + trro_pkg::COLOR_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trro_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [trro_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Request items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_TDATA_W-1:0]             s_tdata,   // corner_a_x, corner_a_y,
                                                         // corner_b_x, corner_b_y
    input  logic                              s_tuser,   // req_type

    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic                              m_tuser,   // write_enable
    output logic                              m_tlast    // last_write
);

    localparam int C    = COORD_BITS;
    localparam int EW   = COORD_BITS + 2;                  // Bresenham error
    localparam int R_W  = $clog2(MAX_BRUSH + 1);           // stamp radius
    localparam int CW   = trro_pkg::CANVAS_REG_W;
    localparam int SW   = ((C > CW) ? C : CW) + R_W + 1;   // stamp bound math
    localparam int PADW = OUT_TDATA_W - 2 * PIX_W - trro_pkg::COLOR_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [CW-1:0]                        canvas_w_reg;
    logic [CW-1:0]                        canvas_h_reg;
    logic [trro_pkg::BRUSH_REG_W-1:0]     brush_reg;
    logic [trro_pkg::COLOR_W-1:0]         color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg <= trro_pkg::CANVAS_W_RST;
            canvas_h_reg <= trro_pkg::CANVAS_H_RST;
            brush_reg    <= trro_pkg::BRUSH_RST;
            color_reg    <= trro_pkg::COLOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (trro_pkg::cfg_index_t'(cfg_index))
                trro_pkg::CFG_CANVAS_WIDTH:  canvas_w_reg <= cfg_data[CW-1:0];
                trro_pkg::CFG_CANVAS_HEIGHT: canvas_h_reg <= cfg_data[CW-1:0];
                trro_pkg::CFG_BRUSH_SIZE:
                    brush_reg <= cfg_data[trro_pkg::BRUSH_REG_W-1:0];
                trro_pkg::CFG_DRAW_COLOR:    color_reg <= cfg_data[trro_pkg::COLOR_W-1:0];
                default:                     color_reg <= color_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Drawing state
    // ------------------------------------------------------------------------
    logic                     busy_reg, busy_next;
    trro_pkg::edge_t          edge_reg, edge_next;
    logic signed [C-1:0]      bnd_l_reg, bnd_t_reg, bnd_r_reg, bnd_b_reg;
    logic signed [C-1:0]      bnd_l_next, bnd_t_next, bnd_r_next, bnd_b_next;
    logic signed [C-1:0]      pt_x_reg, pt_y_reg, pt_x_next, pt_y_next;
    logic signed [C-1:0]      end_x_reg, end_y_reg, end_x_next, end_y_next;
    logic [C-1:0]             dx_reg, dy_reg, dx_next, dy_next;
    logic                     dir_x_reg, dir_y_reg, dir_x_next, dir_y_next;
    logic signed [EW-1:0]     err_reg, err_next;
    logic [PIX_W-1:0]         st_lx_reg, st_ly_reg, st_hx_reg, st_hy_reg;
    logic [PIX_W-1:0]         st_lx_next, st_ly_next, st_hx_next, st_hy_next;
    logic                     st_empty_reg, st_empty_next;
    logic [PIX_W-1:0]         scan_x_reg, scan_y_reg, scan_x_next, scan_y_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_we_reg, out_we_next;
    logic [PIX_W-1:0]             out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic [trro_pkg::COLOR_W-1:0] out_color_reg, out_color_next;
    logic                         out_last_reg, out_last_next;

    // ------------------------------------------------------------------------
    // Combinational step
    // ------------------------------------------------------------------------
    logic                 in_fire, is_start, is_step;
    logic signed [C-1:0]  ax, ay, bx, by;
    logic signed [C-1:0]  src_l, src_t, src_r, src_b;
    logic                 stamp_done, at_end, ne_valid, line_begin, stamp_begin;
    trro_pkg::edge_t      ne, sel_edge;
    logic signed [C-1:0]  x0, y0, x1, y1;
    logic signed [C:0]    dxs, dys;
    logic signed [EW:0]   e2;
    logic                 mv_x, mv_y;
    logic signed [C-1:0]  adv_x, adv_y;
    logic signed [C-1:0]  sp_x, sp_y;
    logic [R_W-1:0]       rad;
    logic [CW-1:0]        w_sat, h_sat;
    logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y, w_m1, h_m1, rad_s;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_start = in_fire && (s_tuser == trro_pkg::REQ_START);
    assign is_step  = in_fire && (s_tuser == trro_pkg::REQ_STEP) && busy_reg;

    assign ax = s_tdata[C-1:0];
    assign ay = s_tdata[2*C-1:C];
    assign bx = s_tdata[3*C-1:2*C];
    assign by = s_tdata[4*C-1:3*C];

    always_comb
    begin
        // Order the corners on a start, else keep the stored rectangle
        if (is_start)
        begin
            src_l = (ax < bx) ? ax : bx;
            src_r = (ax < bx) ? bx : ax;
            src_t = (ay < by) ? ay : by;
            src_b = (ay < by) ? by : ay;
        end
        else
        begin
            src_l = bnd_l_reg;
            src_r = bnd_r_reg;
            src_t = bnd_t_reg;
            src_b = bnd_b_reg;
        end

        // Next edge to draw; skip a bottom that equals the top, a right that
        // equals the left
        ne_valid = 1'b1;
        ne       = trro_pkg::EDGE_LEFT;
        unique case (edge_reg)
            trro_pkg::EDGE_TOP:
                ne = (bnd_b_reg != bnd_t_reg) ? trro_pkg::EDGE_BOTTOM : trro_pkg::EDGE_LEFT;
            trro_pkg::EDGE_BOTTOM:
                ne = trro_pkg::EDGE_LEFT;
            trro_pkg::EDGE_LEFT:
            begin
                ne       = trro_pkg::EDGE_RIGHT;
                ne_valid = (bnd_r_reg != bnd_l_reg);
            end
            trro_pkg::EDGE_RIGHT:
                ne_valid = 1'b0;
            default:
                ne_valid = 1'b0;
        endcase

        // Scan the current stamp; an empty stamp finishes at once
        stamp_done  = st_empty_reg;
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        if (is_step && !st_empty_reg)
        begin
            if (scan_x_reg < st_hx_reg)
            begin
                scan_x_next = scan_x_reg + PIX_W'(1);
            end
            else if (scan_y_reg < st_hy_reg)
            begin
                scan_x_next = st_lx_reg;
                scan_y_next = scan_y_reg + PIX_W'(1);
            end
            else
            begin
                stamp_done = 1'b1;
            end
        end

        at_end      = (pt_x_reg == end_x_reg) && (pt_y_reg == end_y_reg);
        line_begin  = is_start || (is_step && stamp_done && at_end && ne_valid);
        stamp_begin = line_begin || (is_step && stamp_done && !at_end);
        sel_edge    = is_start ? trro_pkg::EDGE_TOP : ne;

        // Line endpoints of the selected edge
        unique case (sel_edge)
            trro_pkg::EDGE_TOP:    begin x0 = src_l; y0 = src_t; x1 = src_r; y1 = src_t; end
            trro_pkg::EDGE_BOTTOM: begin x0 = src_l; y0 = src_b; x1 = src_r; y1 = src_b; end
            trro_pkg::EDGE_LEFT:   begin x0 = src_l; y0 = src_t; x1 = src_l; y1 = src_b; end
            trro_pkg::EDGE_RIGHT:  begin x0 = src_r; y0 = src_t; x1 = src_r; y1 = src_b; end
            default:               begin x0 = src_l; y0 = src_t; x1 = src_r; y1 = src_t; end
        endcase
        dxs = (C+1)'(x1) - (C+1)'(x0);
        dys = (C+1)'(y1) - (C+1)'(y0);

        // Bresenham advance of the stored line
        e2    = {err_reg, 1'b0};
        mv_x  = e2 > -$signed({3'b000, dy_reg});
        mv_y  = e2 < $signed({1'b0, dx_reg});
        adv_x = pt_x_reg;
        adv_y = pt_y_reg;
        if (mv_x)
        begin
            adv_x = dir_x_reg ? pt_x_reg + C'(1) : pt_x_reg - C'(1);
        end
        if (mv_y)
        begin
            adv_y = dir_y_reg ? pt_y_reg + C'(1) : pt_y_reg - C'(1);
        end

        // Stamp around the new point, clipped to the canvas
        sp_x = line_begin ? x0 : adv_x;
        sp_y = line_begin ? y0 : adv_y;
        if (brush_reg == '0)
        begin
            rad = '0;
        end
        else if (int'(brush_reg) > MAX_BRUSH)
        begin
            rad = R_W'(MAX_BRUSH - 1);
        end
        else
        begin
            rad = R_W'(brush_reg - trro_pkg::BRUSH_REG_W'(1));
        end
        w_sat = (int'(canvas_w_reg) > MAX_CANVAS) ? CW'(MAX_CANVAS) : canvas_w_reg;
        h_sat = (int'(canvas_h_reg) > MAX_CANVAS) ? CW'(MAX_CANVAS) : canvas_h_reg;
        rad_s = $signed(SW'(rad));
        w_m1  = $signed(SW'(w_sat)) - $signed(SW'(1));
        h_m1  = $signed(SW'(h_sat)) - $signed(SW'(1));
        lo_x  = SW'(sp_x) - rad_s;
        lo_y  = SW'(sp_y) - rad_s;
        hi_x  = SW'(sp_x) + rad_s;
        hi_y  = SW'(sp_y) + rad_s;
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (hi_x > w_m1) hi_x = w_m1;
        if (hi_y > h_m1) hi_y = h_m1;

        // Next state defaults: hold
        busy_next     = busy_reg;
        edge_next     = edge_reg;
        bnd_l_next    = bnd_l_reg;
        bnd_t_next    = bnd_t_reg;
        bnd_r_next    = bnd_r_reg;
        bnd_b_next    = bnd_b_reg;
        pt_x_next     = pt_x_reg;
        pt_y_next     = pt_y_reg;
        end_x_next    = end_x_reg;
        end_y_next    = end_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dir_x_next    = dir_x_reg;
        dir_y_next    = dir_y_reg;
        err_next      = err_reg;
        st_lx_next    = st_lx_reg;
        st_ly_next    = st_ly_reg;
        st_hx_next    = st_hx_reg;
        st_hy_next    = st_hy_reg;
        st_empty_next = st_empty_reg;

        if (is_start)
        begin
            busy_next  = 1'b1;
            bnd_l_next = src_l;
            bnd_t_next = src_t;
            bnd_r_next = src_r;
            bnd_b_next = src_b;
        end
        else if (is_step && stamp_done && at_end && !ne_valid)
        begin
            busy_next = 1'b0;
        end

        if (line_begin)
        begin
            edge_next  = sel_edge;
            pt_x_next  = x0;
            pt_y_next  = y0;
            end_x_next = x1;
            end_y_next = y1;
            dx_next    = (dxs < 0) ? C'(-dxs) : C'(dxs);
            dy_next    = (dys < 0) ? C'(-dys) : C'(dys);
            dir_x_next = x0 < x1;
            dir_y_next = y0 < y1;
            err_next   = $signed({2'b00, dx_next}) - $signed({2'b00, dy_next});
        end
        else if (is_step && stamp_done && !at_end)
        begin
            pt_x_next = adv_x;
            pt_y_next = adv_y;
            err_next  = err_reg - (mv_x ? $signed({2'b00, dy_reg}) : '0)
                                + (mv_y ? $signed({2'b00, dx_reg}) : '0);
        end

        if (stamp_begin)
        begin
            st_empty_next = (lo_x > hi_x) || (lo_y > hi_y);
            st_lx_next    = lo_x[PIX_W-1:0];
            st_ly_next    = lo_y[PIX_W-1:0];
            st_hx_next    = hi_x[PIX_W-1:0];
            st_hy_next    = hi_y[PIX_W-1:0];
            scan_x_next   = lo_x[PIX_W-1:0];
            scan_y_next   = lo_y[PIX_W-1:0];
        end

        // Result register: load on a step, drop once taken
        out_valid_next = out_valid_reg && !m_tready;
        out_we_next    = out_we_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        if (is_step)
        begin
            out_valid_next = 1'b1;
            out_we_next    = !st_empty_reg;
            out_x_next     = st_empty_reg ? '0 : scan_x_reg;
            out_y_next     = st_empty_reg ? '0 : scan_y_reg;
            out_color_next = st_empty_reg ? '0 : color_reg;
            out_last_next  = stamp_done && at_end && !ne_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            edge_reg      <= trro_pkg::EDGE_TOP;
            bnd_l_reg     <= '0;
            bnd_t_reg     <= '0;
            bnd_r_reg     <= '0;
            bnd_b_reg     <= '0;
            pt_x_reg      <= '0;
            pt_y_reg      <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dir_x_reg     <= 1'b0;
            dir_y_reg     <= 1'b0;
            err_reg       <= '0;
            st_lx_reg     <= '0;
            st_ly_reg     <= '0;
            st_hx_reg     <= '0;
            st_hy_reg     <= '0;
            st_empty_reg  <= 1'b0;
            scan_x_reg    <= '0;
            scan_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_we_reg    <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_color_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            edge_reg      <= edge_next;
            bnd_l_reg     <= bnd_l_next;
            bnd_t_reg     <= bnd_t_next;
            bnd_r_reg     <= bnd_r_next;
            bnd_b_reg     <= bnd_b_next;
            pt_x_reg      <= pt_x_next;
            pt_y_reg      <= pt_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
            err_reg       <= err_next;
            st_lx_reg     <= st_lx_next;
            st_ly_reg     <= st_ly_next;
            st_hx_reg     <= st_hx_next;
            st_hy_reg     <= st_hy_next;
            st_empty_reg  <= st_empty_next;
            scan_x_reg    <= scan_x_next;
            scan_y_reg    <= scan_y_next;
            out_valid_reg <= out_valid_next;
            out_we_reg    <= out_we_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_color_reg <= out_color_next;
            out_last_reg  <= out_last_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PADW{1'b0}}, out_color_reg, out_y_reg, out_x_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A step taken during a drawing always leaves a result in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == trro_pkg::REQ_STEP) && busy_reg)
            |=> out_valid_reg)
        else $error("step during a drawing gave no result");

    // The scan position stays inside a non-empty stamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !st_empty_reg)
            |-> (scan_x_reg >= st_lx_reg) && (scan_x_reg <= st_hx_reg) &&
                (scan_y_reg >= st_ly_reg) && (scan_y_reg <= st_hy_reg))
        else $error("scan position left the stamp");

    // The final tick ends the drawing
    assert property (@(posedge clk) disable iff (!rst_n)
        (is_step && out_last_next) |=> !busy_reg)
        else $error("drawing still busy after its last tick");

    // An empty tick carries no coordinates and no color
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_we_reg)
            |-> (out_x_reg == '0) && (out_y_reg == '0) && (out_color_reg == '0))
        else $error("empty tick with nonzero payload");

endmodule

FILE: bench/testbench.sv
// ============================================================================
// testbench - self-checking bench for the thick rectangle outline rasterizer
// Drives start and step items into the block, predicts every pixel write with
// an independent Bresenham and stamp-scan model, and compares each result item
// field by field. Runs through several canvas, brush and color settings under
// changing sender and receiver idling.
// ============================================================================
typedef struct packed {
    logic        write_enable;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] color;
    logic        last_write;
} pixel_t;

class raster_scoreboard;
    logic [trro_pkg::CANVAS_REG_W-1:0] canvas_w;
    logic [trro_pkg::CANVAS_REG_W-1:0] canvas_h;
    logic [trro_pkg::BRUSH_REG_W-1:0]  brush;
    logic [trro_pkg::COLOR_W-1:0]      color;

    bit              busy;
    trro_pkg::edge_t edge_sel;
    int              rect[4];        // left, top, right, bottom
    int              point[2];
    int              line_end[2];
    int              delta[2];
    bit              step_dir[2];    // 1 walks toward larger coordinates
    int              err;
    int              stamp[4];       // clipped stamp: left, top, right, bottom
    int              scan[2];
    pixel_t          pending_pixels[$];
    int              errors;

    function new();
        canvas_w = trro_pkg::CANVAS_W_RST;
        canvas_h = trro_pkg::CANVAS_H_RST;
        brush    = trro_pkg::BRUSH_RST;
        color    = trro_pkg::COLOR_RST;
        busy     = 1'b0;
        edge_sel = trro_pkg::EDGE_TOP;
        err      = 0;
        errors   = 0;
    endfunction

    function int lo(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function int hi(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function void write_register(trro_pkg::cfg_index_t idx,
                                 logic [trro_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            trro_pkg::CFG_CANVAS_WIDTH:  canvas_w = data[trro_pkg::CANVAS_REG_W-1:0];
            trro_pkg::CFG_CANVAS_HEIGHT: canvas_h = data[trro_pkg::CANVAS_REG_W-1:0];
            trro_pkg::CFG_BRUSH_SIZE:    brush    = data[trro_pkg::BRUSH_REG_W-1:0];
            trro_pkg::CFG_DRAW_COLOR:    color    = data[trro_pkg::COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // Clip the square around the current line point to the canvas.
    function void open_stamp();
        int w;
        int h;
        int b;
        int r;
        w = (canvas_w > trro_pkg::MAX_CANVAS_DEF) ? trro_pkg::MAX_CANVAS_DEF : int'(canvas_w);
        h = (canvas_h > trro_pkg::MAX_CANVAS_DEF) ? trro_pkg::MAX_CANVAS_DEF : int'(canvas_h);
        b = (brush == 0) ? 1 :
            ((brush > trro_pkg::MAX_BRUSH_DEF) ? trro_pkg::MAX_BRUSH_DEF : int'(brush));
        r = b - 1;
        stamp[0] = hi(0, point[0] - r);
        stamp[1] = hi(0, point[1] - r);
        stamp[2] = lo(w - 1, point[0] + r);
        stamp[3] = lo(h - 1, point[1] + r);
        scan[0]  = stamp[0];
        scan[1]  = stamp[1];
    endfunction

    function void open_line(int x0, int y0, int x1, int y1);
        point[0]    = x0;
        point[1]    = y0;
        line_end[0] = x1;
        line_end[1] = y1;
        delta[0]    = (x1 > x0) ? x1 - x0 : x0 - x1;
        delta[1]    = (y1 > y0) ? y1 - y0 : y0 - y1;
        step_dir[0] = (x0 < x1);
        step_dir[1] = (y0 < y1);
        err         = delta[0] - delta[1];
        open_stamp();
    endfunction

    // Skip a bottom edge on the top row and a right edge on the left column.
    function bit open_edge(int first);
        for (int e = first; e < 4; e++)
        begin
            if (e == trro_pkg::EDGE_BOTTOM && rect[3] == rect[1]) continue;
            if (e == trro_pkg::EDGE_RIGHT && rect[2] == rect[0]) continue;
            edge_sel = trro_pkg::edge_t'(e);
            case (edge_sel)
                trro_pkg::EDGE_TOP:    open_line(rect[0], rect[1], rect[2], rect[1]);
                trro_pkg::EDGE_BOTTOM: open_line(rect[0], rect[3], rect[2], rect[3]);
                trro_pkg::EDGE_LEFT:   open_line(rect[0], rect[1], rect[0], rect[3]);
                default:               open_line(rect[2], rect[1], rect[2], rect[3]);
            endcase
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void accept_request(logic kind, logic [47:0] data);
        int     ax;
        int     ay;
        int     bx;
        int     by;
        int     e2;
        bit     stamp_done;
        pixel_t px;
        if (kind == trro_pkg::REQ_START)
        begin
            ax = $signed(data[11:0]);
            ay = $signed(data[23:12]);
            bx = $signed(data[35:24]);
            by = $signed(data[47:36]);
            rect[0] = lo(ax, bx);
            rect[1] = lo(ay, by);
            rect[2] = hi(ax, bx);
            rect[3] = hi(ay, by);
            busy = open_edge(0);
            return;
        end
        if (!busy) return;

        px = '0;
        stamp_done = 1'b0;
        if (stamp[0] > stamp[2] || stamp[1] > stamp[3])
        begin
            stamp_done = 1'b1;
        end
        else
        begin
            px.write_enable = 1'b1;
            px.x     = scan[0][9:0];
            px.y     = scan[1][9:0];
            px.color = color;
            if (scan[0] < stamp[2])
            begin
                scan[0]++;
            end
            else if (scan[1] < stamp[3])
            begin
                scan[0] = stamp[0];
                scan[1]++;
            end
            else
            begin
                stamp_done = 1'b1;
            end
        end

        if (stamp_done)
        begin
            if (point[0] == line_end[0] && point[1] == line_end[1])
            begin
                if (!open_edge(int'(edge_sel) + 1))
                begin
                    busy = 1'b0;
                    px.last_write = 1'b1;
                end
            end
            else
            begin
                e2 = err * 2;
                if (e2 > -delta[1])
                begin
                    err -= delta[1];
                    point[0] += step_dir[0] ? 1 : -1;
                end
                if (e2 < delta[0])
                begin
                    err += delta[0];
                    point[1] += step_dir[1] ? 1 : -1;
                end
                open_stamp();
            end
        end
        pending_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item: we=%0b x=%0d y=%0d color=%h last=%0b",
                         got.write_enable, got.x, got.y, got.color, got.last_write);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.write_enable !== want.write_enable || got.x !== want.x ||
            got.y !== want.y || got.color !== want.color ||
            got.last_write !== want.last_write)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("pixel mismatch: expected we=%0b x=%0d y=%0d color=%h last=%0b",
                         want.write_enable, want.x, want.y, want.color, want.last_write);
                $display("                got      we=%0b x=%0d y=%0d color=%h last=%0b",
                         got.write_enable, got.x, got.y, got.color, got.last_write);
            end
        end
    endfunction
endclass

module testbench;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int STEP_CAP    = 150;   // most steps spent on one rectangle
    localparam int DRAIN_LIMIT = 5000;  // cycles allowed for results to drain

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    trro_pkg::cfg_index_t              cfg_index = trro_pkg::CFG_CANVAS_WIDTH;
    logic [trro_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [47:0]                       s_tdata   = '0;  // corner_a_x, corner_a_y,
                                                         // corner_b_x, corner_b_y
    logic                              s_tuser   = trro_pkg::REQ_STEP;  // req_type
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [55:0]                       m_tdata;         // pixel_x, pixel_y, pixel_color
    logic                              m_tuser;         // write_enable
    logic                              m_tlast;         // last_write

    raster_scoreboard sb;
    int send_pct      = 0;  // chance in a hundred that the sender idles a cycle
    int recv_pct      = 0;  // chance in a hundred that the receiver stalls a cycle
    int hold_requests = 0;  // long hold-offs asked for so far

    thick_rectangle_outline_raster u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: stall at the rate of the current phase; on request, hold off
    // for a long stretch so the result stage fills and the input backs up.
    initial
    begin : receiver
        int hold_served;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // Result monitor: sample between edges, where the handshake signals are
    // settled; the item moves at the next rising edge.
    initial
    begin : result_monitor
        pixel_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready)
            begin
                got.write_enable = m_tuser;
                got.x            = m_tdata[9:0];
                got.y            = m_tdata[19:10];
                got.color        = m_tdata[51:20];
                got.last_write   = m_tlast;
                sb.check_pixel(got);
            end
        end
    end

    function automatic logic [47:0] corners(int ax, int ay, int bx, int by);
        return {by[11:0], bx[11:0], ay[11:0], ax[11:0]};
    endfunction

    function automatic int clamp_coord(int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    function automatic logic [47:0] noise48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Offer one item; return right after the edge that takes it, with valid
    // still high so back-to-back items need no extra edge.
    task automatic send_request(logic kind, logic [47:0] data);
        bit took;
        if ($urandom_range(99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        sb.accept_request(kind, data);
    endtask

    // Write all four registers back to back; garbage above the canvas and brush fields.
    task automatic program_registers(logic [10:0] w, logic [10:0] h,
                                     logic [6:0] b, logic [31:0] c);
        trro_pkg::cfg_index_t idx;
        logic [31:0]          val;
        bit                   took;
        for (int i = 0; i < 4; i++)
        begin
            idx = trro_pkg::cfg_index_t'(i);
            val = $urandom();
            case (idx)
                trro_pkg::CFG_CANVAS_WIDTH:  val[10:0] = w;
                trro_pkg::CFG_CANVAS_HEIGHT: val[10:0] = h;
                trro_pkg::CFG_BRUSH_SIZE:    val[6:0]  = b;
                default:                     val       = c;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
            sb.write_register(idx, val);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_pct = 61;
                recv_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_pct = 0;
                recv_pct = 61;
            end
            IDLE_BOTH:
            begin
                send_pct = 27;
                recv_pct = 27;
            end
            default:
            begin
                send_pct = 0;
                recv_pct = 0;
            end
        endcase
    endtask

    // Mostly full start-and-step sequences on small rectangles near the
    // canvas; some get cut short by the next start, some lie far away or
    // span the whole coordinate range, and a few lone steps are noise.
    task automatic run_random(int budget);
        int used;
        int steps;
        int roll;
        int shape;
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        bit was_busy;
        used = 0;
        while (used < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                was_busy = sb.busy;
                send_request(trro_pkg::REQ_STEP, noise48());
                if (was_busy) used++;
                continue;
            end
            w = (sb.canvas_w > trro_pkg::MAX_CANVAS_DEF) ?
                trro_pkg::MAX_CANVAS_DEF : int'(sb.canvas_w);
            h = (sb.canvas_h > trro_pkg::MAX_CANVAS_DEF) ?
                trro_pkg::MAX_CANVAS_DEF : int'(sb.canvas_h);
            shape = $urandom_range(9);
            if (shape < 7)
            begin
                x0 = int'($urandom_range(0, w + 16)) - 8;
                y0 = int'($urandom_range(0, h + 16)) - 8;
                x1 = x0 + int'($urandom_range(0, 12)) - 6;
                y1 = y0 + int'($urandom_range(0, 12)) - 6;
            end
            else if (shape < 9)
            begin
                x0 = $signed(12'($urandom()));
                y0 = $signed(12'($urandom()));
                x1 = clamp_coord(x0 + int'($urandom_range(0, 8)) - 4);
                y1 = clamp_coord(y0 + int'($urandom_range(0, 8)) - 4);
            end
            else
            begin
                x0 = $signed(12'($urandom()));
                y0 = $signed(12'($urandom()));
                x1 = $signed(12'($urandom()));
                y1 = $signed(12'($urandom()));
            end
            send_request(trro_pkg::REQ_START, corners(x0, y0, x1, y1));
            used++;
            steps = (roll < 75) ? STEP_CAP : int'($urandom_range(0, 20));
            while (steps > 0 && sb.busy)
            begin
                send_request(trro_pkg::REQ_STEP, noise48());
                used++;
                steps--;
            end
        end
    endtask

    // Finish any rectangle in progress, drop valid and let results drain.
    task automatic close_out();
        int n;
        if (sb.busy)
        begin
            // far off the canvas every stamp clips empty: two ticks and done
            send_request(trro_pkg::REQ_START, corners(-2000, -2000, -2000, -2000));
            while (sb.busy) send_request(trro_pkg::REQ_STEP, noise48());
        end
        s_tvalid <= 1'b0;
        n = 0;
        while (sb.pending_pixels.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(logic [10:0] w, logic [10:0] h, logic [6:0] b,
                             logic [31:0] c, idle_mode_t mode, bit squeeze,
                             int budget);
        program_registers(w, h, b, c);
        set_idle(mode);
        if (squeeze)
        begin
            // keep offering steps while the receiver holds off
            send_request(trro_pkg::REQ_START, corners(3, 3, 20, 20));
            hold_requests++;
            repeat (40) send_request(trro_pkg::REQ_STEP, noise48());
        end
        run_random(budget);
        close_out();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, reset register values, no idling.
        set_idle(IDLE_NONE);
        send_request(trro_pkg::REQ_STEP, '1);                         // step while idle
        send_request(trro_pkg::REQ_START, corners(-2048, -2048, 2047, 2047));
        repeat (4) send_request(trro_pkg::REQ_STEP, '0);              // empty stamps
        send_request(trro_pkg::REQ_START, corners(2047, 2047, -2048, -2048)); // replace
        repeat (3) send_request(trro_pkg::REQ_STEP, '1);
        send_request(trro_pkg::REQ_START, corners(2, 1, 1, 0));       // small, run to end
        while (sb.busy) send_request(trro_pkg::REQ_STEP, noise48());
        send_request(trro_pkg::REQ_START, corners(62, 63, 65, 63));   // row over the border
        while (sb.busy) send_request(trro_pkg::REQ_STEP, noise48());
        send_request(trro_pkg::REQ_STEP, noise48());                  // idle again
        close_out();

        // Random phases: canvas and brush extremes, saturating values,
        // zero canvas and zero brush, color extremes.
        run_phase(11'd64,   11'd64,   7'd1,   $urandom(),    IDLE_NONE,     1'b1, 150);
        run_phase(11'd1024, 11'd1024, 7'd3,   32'h0,         IDLE_SENDER,   1'b0, 150);
        run_phase(11'd0,    11'd40,   7'd2,   32'hFFFF_FFFF, IDLE_RECEIVER, 1'b0, 150);
        run_phase(11'd2047, 11'd2047, 7'd0,   $urandom(),    IDLE_BOTH,     1'b0, 150);
        run_phase(11'd1,    11'd1,    7'd64,  $urandom(),    IDLE_NONE,     1'b0, 150);
        run_phase(11'd100,  11'd37,   7'd127, $urandom(),    IDLE_SENDER,   1'b0, 150);
        run_phase(11'd64,   11'd64,   7'd5,   $urandom(),    IDLE_RECEIVER, 1'b0, 150);
        run_phase(11'd512,  11'd300,  7'd1,   $urandom(),    IDLE_BOTH,     1'b0, 150);

        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
